[hw/rtl/multi_press_button_counter_assert.svh]
// Assertion macros for the multi-press button counter.
`ifndef MULTI_PRESS_BUTTON_COUNTER_ASSERT_SVH
`define MULTI_PRESS_BUTTON_COUNTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked outside reset.
`define MPB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("multi_press_button_counter: check failed");

// Checked in every cycle, reset included.
`define MPB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("multi_press_button_counter: check failed");

`else

`define MPB_ASSERT(lbl, prop)
`define MPB_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[hw/rtl/mpbc_pkg.sv]
// Constants and phase codes for the multi-press button counter.
`timescale 1ns / 1ps
`default_nettype none

package mpbc_pkg;

    localparam int TICK_COUNT_BITS = 16;
    localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RELEASE_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP_TICKS     = 2'd3;

    localparam logic [CFG_BITS-1:0] MIN_PRESS_RESET   = 16'd10;
    localparam logic [CFG_BITS-1:0] MIN_RELEASE_RESET = 16'd10;
    localparam logic [CFG_BITS-1:0] MAX_GAP_RESET     = 16'd80;

    typedef logic [2:0] t_phase;

    localparam t_phase PH_WAIT_PRESS   = 3'd0;
    localparam t_phase PH_QUAL_PRESS   = 3'd1;
    localparam t_phase PH_WAIT_RELEASE = 3'd2;
    localparam t_phase PH_QUAL_RELEASE = 3'd3;
    localparam t_phase PH_WAIT_NEXT    = 3'd4;
    localparam t_phase PH_REPORT       = 3'd5;

    // Elapsed time strictly above a configured limit.
    function automatic logic ticks_above(input logic [TICK_COUNT_BITS-1:0] ticks,
                                         input logic [CFG_BITS-1:0] limit);
        return 33'(ticks) > 33'(limit);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/multi_press_button_counter.sv]
// Debounced multi-press button counter with stream ports and a config write port.
//
// channel   dir  fields (lowest bit up)                    handshake
// s_axis    in   tdata: button_level, zero fill             tvalid/tready
// m_axis    out  tdata: report_valid, reported_presses,     tvalid/tready
//                zero fill
// cfg       in   i_cfg_addr, i_cfg_data                     i_cfg_we
//
// One tick per cycle: the phase update is one compare and a saturating add
// between the state registers and the output register.
// The output register frees itself in the cycle it transfers, so a tick is
// taken every cycle while m_axis_tready is high.
// Synchronous active-low reset clears phase, counters and valid, and loads the config defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_press_button_counter_assert.svh"

module multi_press_button_counter
    import mpbc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_BITS-1:0]    i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] button_level
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output      logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] report_valid, [8:1] presses
);

    logic                       r_pressed_level;
    logic [CFG_BITS-1:0]        r_min_press;
    logic [CFG_BITS-1:0]        r_min_release;
    logic [CFG_BITS-1:0]        r_max_gap;

    t_phase                     r_phase, n_phase;
    logic [TICK_COUNT_BITS-1:0] r_elapsed, n_elapsed;
    logic [COUNT_BITS-1:0]      r_count, n_count;

    logic                       r_out_valid;
    logic                       r_out_report, n_out_report;
    logic [COUNT_BITS-1:0]      r_out_count, n_out_count;

    logic                       s_xfer;
    logic                       pressed;
    logic [TICK_COUNT_BITS-1:0] ticked;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign pressed       = (s_axis_tdata[0] == r_pressed_level);
    assign ticked        = (r_elapsed != TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;

    always_comb begin
        n_phase      = r_phase;
        n_elapsed    = ticked;
        n_count      = r_count;
        n_out_report = 1'b0;
        n_out_count  = '0;
        unique case (r_phase)
            PH_WAIT_PRESS: begin
                if (pressed) begin
                    n_elapsed = '0;
                    n_phase   = PH_QUAL_PRESS;
                end
            end
            PH_QUAL_PRESS: begin
                if (!pressed) begin
                    n_phase = PH_REPORT;
                end else if (ticks_above(ticked, r_min_press)) begin
                    n_phase = PH_WAIT_RELEASE;
                end
            end
            PH_WAIT_RELEASE: begin
                if (!pressed) begin
                    n_elapsed = '0;
                    n_phase   = PH_QUAL_RELEASE;
                end
            end
            PH_QUAL_RELEASE: begin
                if (pressed) begin
                    n_phase = PH_REPORT;
                end else if (ticks_above(ticked, r_min_release)) begin
                    n_phase   = PH_WAIT_NEXT;
                    n_elapsed = '0;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            PH_WAIT_NEXT: begin
                if (ticks_above(ticked, r_max_gap)) begin
                    n_phase = PH_REPORT;
                end else if (pressed) begin
                    n_phase = PH_WAIT_PRESS;
                end
            end
            PH_REPORT: begin
                if (r_count != '0) begin
                    n_out_report = 1'b1;
                    n_out_count  = r_count;
                end
                n_phase = PH_WAIT_PRESS;
                n_count = '0;
            end
            default: begin
                n_phase = PH_WAIT_PRESS;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_level <= 1'b0;
            r_min_press     <= MIN_PRESS_RESET;
            r_min_release   <= MIN_RELEASE_RESET;
            r_max_gap       <= MAX_GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PRESSED_LEVEL:     r_pressed_level <= i_cfg_data[0];
                REG_MIN_PRESS_TICKS:   r_min_press     <= i_cfg_data;
                REG_MIN_RELEASE_TICKS: r_min_release   <= i_cfg_data;
                REG_MAX_GAP_TICKS:     r_max_gap       <= i_cfg_data;
                default:               r_max_gap       <= r_max_gap;
            endcase
        end
    end

    // Advance the tick state on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT_PRESS;
            r_elapsed <= '0;
            r_count   <= '0;
        end else if (s_xfer) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_out_report <= n_out_report;
            r_out_count  <= n_out_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-COUNT_BITS-1){1'b0}}, r_out_count, r_out_report};

    `MPB_ASSERT(a_report_nonzero, (r_out_valid && r_out_report) |-> (r_out_count != '0))
    `MPB_ASSERT(a_report_clears,
        (s_xfer && r_phase == PH_REPORT) |=> (r_phase == PH_WAIT_PRESS && r_count == '0))
    `MPB_ASSERT(a_press_restarts_time,
        (s_xfer && r_phase == PH_WAIT_PRESS && pressed) |=> (r_elapsed == '0))
    `MPB_ASSERT_ALWAYS(a_free_when_empty, !r_out_valid |-> s_axis_tready)

endmodule

`default_nettype wire

[tb/multi_press_button_counter_test.sv]
// Stream testbench for the multi-press button counter: directed table, a count-ceiling run, then random press series.
`timescale 1ns / 1ps

module multi_press_button_counter_test;
    import mpbc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_DIR = 20;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 30;
    localparam int RUN_CAP = 30;

    typedef struct packed {
        logic                  valid;
        logic [COUNT_BITS-1:0] presses;
    } report_t;

    typedef struct packed {
        logic                  lvl;
        int                    reps;
        logic                  typed;
        logic                  valid;
        logic [COUNT_BITS-1:0] presses;
    } dir_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_addr;
    logic [CFG_BITS-1:0]    i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [0] button_level, zero fill
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [0] report_valid, [8:1] reported_presses

    multi_press_button_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    report_t expected_reports[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      items_sent = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    logic                       det_pressed_level;
    logic [CFG_BITS-1:0]        det_min_press;
    logic [CFG_BITS-1:0]        det_min_release;
    logic [CFG_BITS-1:0]        det_max_gap;
    t_phase                     det_phase;
    logic [TICK_COUNT_BITS-1:0] det_elapsed;
    logic [COUNT_BITS-1:0]      det_count;

    // Reset config: level 0 is pressed, press and release > 10 ticks, gap 80.
    dir_row_t dir_rows [N_DIR] = '{
        '{1'b1,  4, 1'b1, 1'b0, 8'd0},
        '{1'b0, 12, 1'b0, 1'b0, 8'd0},
        '{1'b1, 12, 1'b0, 1'b0, 8'd0},
        '{1'b0, 13, 1'b0, 1'b0, 8'd0},
        '{1'b1, 12, 1'b0, 1'b0, 8'd0},
        '{1'b1, 81, 1'b0, 1'b0, 8'd0},
        '{1'b1,  1, 1'b1, 1'b1, 8'd2},
        '{1'b0,  5, 1'b0, 1'b0, 8'd0},
        '{1'b1,  1, 1'b0, 1'b0, 8'd0},
        '{1'b0,  1, 1'b1, 1'b0, 8'd0},
        '{1'b1,  2, 1'b0, 1'b0, 8'd0},
        '{1'b0, 12, 1'b0, 1'b0, 8'd0},
        '{1'b1, 12, 1'b0, 1'b0, 8'd0},
        '{1'b0, 13, 1'b0, 1'b0, 8'd0},
        '{1'b1,  3, 1'b0, 1'b0, 8'd0},
        '{1'b0,  1, 1'b0, 1'b0, 8'd0},
        '{1'b1,  1, 1'b1, 1'b1, 8'd1},
        '{1'b0, 11, 1'b0, 1'b0, 8'd0},
        '{1'b1,  1, 1'b0, 1'b0, 8'd0},
        '{1'b1,  1, 1'b1, 1'b0, 8'd0}
    };

    function automatic report_t advance_detector(input logic lvl);
        report_t rep;
        logic    pressed;
        rep = '0;
        pressed = (lvl == det_pressed_level);
        if (det_elapsed != TICK_MAX) det_elapsed = det_elapsed + 1'b1;
        case (det_phase)
            PH_WAIT_PRESS: begin
                if (pressed) begin
                    det_elapsed = '0;
                    det_phase = PH_QUAL_PRESS;
                end
            end
            PH_QUAL_PRESS: begin
                if (!pressed) det_phase = PH_REPORT;
                else if (det_elapsed > det_min_press) det_phase = PH_WAIT_RELEASE;
            end
            PH_WAIT_RELEASE: begin
                if (!pressed) begin
                    det_elapsed = '0;
                    det_phase = PH_QUAL_RELEASE;
                end
            end
            PH_QUAL_RELEASE: begin
                if (pressed) begin
                    det_phase = PH_REPORT;
                end else if (det_elapsed > det_min_release) begin
                    det_phase = PH_WAIT_NEXT;
                    det_elapsed = '0;
                    if (det_count != COUNT_MAX) det_count = det_count + 1'b1;
                end
            end
            PH_WAIT_NEXT: begin
                if (det_elapsed > det_max_gap) det_phase = PH_REPORT;
                else if (pressed) det_phase = PH_WAIT_PRESS;
            end
            PH_REPORT: begin
                if (det_count != '0) begin
                    rep.valid = 1'b1;
                    rep.presses = det_count;
                end
                det_phase = PH_WAIT_PRESS;
                det_count = '0;
            end
            default: begin
                det_phase = PH_WAIT_PRESS;
                det_count = '0;
            end
        endcase
        return rep;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 82;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 82;
            end
            default: begin
                send_idle_pct = 12;
                recv_stall_pct = 12;
            end
        endcase
    endtask

    task automatic send_level(input logic lvl, input logic typed, input report_t typed_rep);
        report_t rep;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, lvl};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rep = advance_detector(lvl);
        expected_reports.push_back(typed ? typed_rep : rep);
        items_sent++;
    endtask

    // Hold off the sender until every pending report has come out.
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_BITS-1:0] lvl_word, input logic [CFG_BITS-1:0] mp,
                              input logic [CFG_BITS-1:0] mr, input logic [CFG_BITS-1:0] gp);
        drain_reports();
        write_reg(REG_PRESSED_LEVEL, lvl_word);
        det_pressed_level = lvl_word[0];
        write_reg(REG_MIN_PRESS_TICKS, mp);
        det_min_press = mp;
        write_reg(REG_MIN_RELEASE_TICKS, mr);
        det_min_release = mr;
        write_reg(REG_MAX_GAP_TICKS, gp);
        det_max_gap = gp;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        report_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                $error("report transfer with none pending: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                if (m_axis_tdata[0] !== want.valid) begin
                    $error("report_valid: expected %0d, actual %0d", want.valid, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[COUNT_BITS:1] !== want.presses) begin
                    $error("reported_presses: expected %0d, actual %0d",
                           want.presses, m_axis_tdata[COUNT_BITS:1]);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("multi_press_button_counter: mismatch");
            $finish;
        end
    end

    initial begin
        int   i;
        int   j;
        int   p;
        int   r;
        int   len;
        int   start;
        int   mp_e;
        int   mr_e;
        int   gap_e;
        logic press;
        logic noisy;
        logic paused;
        logic lvl;
        logic [CFG_BITS-1:0] mp;
        logic [CFG_BITS-1:0] mr;
        logic [CFG_BITS-1:0] gp;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        det_pressed_level = 1'b0;
        det_min_press     = MIN_PRESS_RESET;
        det_min_release   = MIN_RELEASE_RESET;
        det_max_gap       = MAX_GAP_RESET;
        det_phase         = PH_WAIT_PRESS;
        det_elapsed       = '0;
        det_count         = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0);
        for (i = 0; i < N_DIR; i++) begin
            for (j = 0; j < dir_rows[i].reps; j++) begin
                send_level(dir_rows[i].lvl, dir_rows[i].typed,
                           '{valid: dir_rows[i].valid, presses: dir_rows[i].presses});
            end
        end

        // Fast presses past the count ceiling, then let the gap run out.
        set_idling(3);
        set_config(16'h0001, 16'd0, 16'd0, 16'd1);
        for (i = 0; i < 257; i++) begin
            send_level(1'b1, 1'b0, '0);
            send_level(1'b1, 1'b0, '0);
            send_level(1'b1, 1'b0, '0);
            send_level(1'b0, 1'b0, '0);
            send_level(1'b0, 1'b0, '0);
        end
        for (i = 0; i < 4; i++) send_level(1'b0, 1'b0, '0);

        for (p = 0; p < RAND_PHASES; p++) begin
            set_idling(p % 4);
            case (p)
                2: begin
                    mp = 16'd0;
                    mr = 16'hFFFF;
                    gp = 16'd0;
                end
                5: begin
                    mp = 16'hFFFF;
                    mr = 16'd0;
                    gp = 16'hFFFF;
                end
                7: begin
                    mp = 16'd0;
                    mr = 16'd0;
                    gp = 16'd0;
                end
                default: begin
                    mp = 16'($urandom_range(0, 6));
                    mr = 16'($urandom_range(0, 6));
                    gp = 16'($urandom_range(1, 24));
                end
            endcase
            set_config(16'($urandom), mp, mr, gp);
            mp_e  = (det_min_press > RUN_CAP) ? RUN_CAP : int'(det_min_press);
            mr_e  = (det_min_release > RUN_CAP) ? RUN_CAP : int'(det_min_release);
            gap_e = (det_max_gap > RUN_CAP) ? RUN_CAP : int'(det_max_gap);
            start = items_sent;
            paused = 1'b0;
            press = 1'b1;
            while (items_sent - start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                noisy = 1'b0;
                if (press) begin
                    if (r < 80) len = mp_e + 2 + $urandom_range(0, 3);
                    else if (r < 95) len = $urandom_range(1, mp_e + 1);
                    else begin
                        len = $urandom_range(1, 8);
                        noisy = 1'b1;
                    end
                end else begin
                    if (r < 55) len = mr_e + 2 + $urandom_range(0, gap_e);
                    else if (r < 80) len = mr_e + gap_e + 4 + $urandom_range(0, 4);
                    else if (r < 95) len = $urandom_range(1, mr_e + 1);
                    else begin
                        len = $urandom_range(1, 8);
                        noisy = 1'b1;
                    end
                end
                for (j = 0; j < len; j++) begin
                    lvl = press ? det_pressed_level : ~det_pressed_level;
                    if (noisy) lvl = 1'($urandom_range(0, 1));
                    send_level(lvl, 1'b0, '0);
                end
                press = ~press;
                if (!paused && (items_sent - start >= PHASE_ITEMS / 2)) begin
                    drain_reports();
                    paused = 1'b1;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("multi_press_button_counter: match");
        end else begin
            $display("multi_press_button_counter: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mpbc_pkg.sv
hw/rtl/multi_press_button_counter.sv
tb/multi_press_button_counter_test.sv
